// ----- design/fgsr_pkg.sv -----
// fgsr_pkg: shared constants, command/status structs and store entry types
`timescale 1ns / 1ps
package fgsr_pkg;

   localparam int FGSR_SNAP_DEPTH = 32;
   localparam int FGSR_INC_DEPTH  = 32;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] KIND_FWD   = 2'd0;
   localparam logic [1:0] KIND_JOIN  = 2'd1;
   localparam logic [1:0] KIND_LEAVE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SEQ   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE   = 2'd2;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LATCH,
      OP_FWD,
      OP_JOIN,
      OP_SNAP_WR,
      OP_MOD_SEQ,
      OP_INC_WR,
      OP_SNAP_CLR,
      OP_RD_SNAP0,
      OP_RD_SNAPN,
      OP_SET_NEXT,
      OP_RD_INC,
      OP_SWEEP,
      OP_MOD_NEXT,
      OP_INIT_INC,
      OP_RD_SNAPI,
      OP_EMIT_SNAP,
      OP_RD_INCSLOT,
      OP_EMIT_INC,
      OP_LEAVE,
      OP_FLUSH
   } fgsr_op_type;

   typedef struct packed {
      fgsr_op_type op;
   } fgsr_cmd_type;

   typedef struct packed {
      logic from_snapshot;
      logic recovering;
      logic seq_hit;
      logic push_ok;
      logic rsp_free;
      logic pend_valid;
      logic snap_empty;
      logic snap_contig;
      logic is_start;
      logic is_end;
      logic sweep_last;
      logic inc_ok;
      logic mod_done;
      logic snap_last;
      logic inc_done;
   } fgsr_stat_type;

   typedef struct packed {
      logic [2:0]  utype;
      logic [31:0] order;
      logic [63:0] body;
   } fgsr_snap_entry_type;

   typedef struct packed {
      logic [31:0] tag;
      logic [2:0]  utype;
      logic [31:0] order;
      logic [63:0] body;
   } fgsr_inc_entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  utype;
      logic [31:0] order;
      logic [63:0] body;
   } fgsr_res_type;

endpackage

// ----- design/feed_gap_snapshot_recovery_core.sv -----
// feed_gap_snapshot_recovery_core: top level, sequencer plus datapath
//
// req_* carries one framed update per beat (tuser = snapshot stream flag).
// rsp_* returns the results of that update: tuser is the kind (forward, join,
// leave), tlast marks the last result of the update. csr_* writes the
// expected sequence number and the start/end type codes; the user must do
// so only while idle, which the block itself does not enforce. One update
// is worked on at a time; req_tready is high only between updates.
// In-order incremental: latched, pushed as the pending result, then moved
// into the output register once it is free, before the next beat is taken.
// A snapshot beat outside recovery is dropped. Buffered update: stored and
// checked, and the check may stop early; an incremental first waits on the
// residue unit. With a full snapshot, the store is swept, replay starts,
// each snapshot entry and each replayed incremental is emitted, then it ends.
// The newest result is held back one beat so that tlast can be set; a stall
// on rsp_tready halts replay without losing anything.
// Reset empties both stores, leaves recovery and expects sequence number 1;
// there is no clearing pass.
`timescale 1ns / 1ps
module feed_gap_snapshot_recovery_core #(
   parameter int SNAP_DEPTH = fgsr_pkg::FGSR_SNAP_DEPTH,
   parameter int INC_DEPTH  = fgsr_pkg::FGSR_INC_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // seq_number, update_type, order_ident, body_bits, zero pad
   input  logic [fgsr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // from_snapshot
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_type, out_order, out_body, zero pad
   output logic [fgsr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result_kind
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [fgsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fgsr_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import fgsr_pkg::*;

   fgsr_cmd_type  cmd;
   fgsr_stat_type stat;

   fgsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fgsr_dp #(
      .SNAP_DEPTH (SNAP_DEPTH),
      .INC_DEPTH  (INC_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .stat        (stat)
   );
endmodule

// ----- design/fgsr_mod.sv -----
// fgsr_mod: serial residue unit, four bits of the dividend per cycle
`timescale 1ns / 1ps
module fgsr_mod #(
   parameter int MODULUS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [32:0]                  value,
   output logic                         done,
   output logic [$clog2(MODULUS)-1:0]   residue
);
   localparam int RW = $clog2(MODULUS);
   localparam int TW = RW + 4;
   localparam logic [TW-1:0] M1 = TW'(MODULUS);
   localparam logic [TW-1:0] M2 = TW'(MODULUS * 2);
   localparam logic [TW-1:0] M4 = TW'(MODULUS * 4);
   localparam logic [TW-1:0] M8 = TW'(MODULUS * 8);

   logic [35:0]   sh_ff, sh_in;
   logic [RW-1:0] r_ff, r_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [TW-1:0] t0, t1, t2, t3, t4;

   always_comb begin
      t0 = {r_ff, sh_ff[35:32]};
      t1 = (t0 >= M8) ? t0 - M8 : t0;
      t2 = (t1 >= M4) ? t1 - M4 : t1;
      t3 = (t2 >= M2) ? t2 - M2 : t2;
      t4 = (t3 >= M1) ? t3 - M1 : t3;
      sh_in  = sh_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      if (start) begin
         sh_in  = {3'b000, value};
         r_in   = '0;
         cnt_in = 4'd9;
      end else if (cnt_ff != 4'd0) begin
         sh_in  = {sh_ff[31:0], 4'h0};
         r_in   = t4[RW-1:0];
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      r_ff  <= r_in;
   end

   assign done    = (cnt_ff == 4'd0);
   assign residue = r_ff;
endmodule

// ----- design/fgsr_dp.sv -----
// fgsr_dp: update registers, snapshot and incremental stores, sync check counters, result stage
`timescale 1ns / 1ps
module fgsr_dp #(
   parameter int SNAP_DEPTH = 32,
   parameter int INC_DEPTH  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tuser,
   input  logic [fgsr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_wr_en,
   input  logic [fgsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fgsr_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fgsr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  fgsr_pkg::fgsr_cmd_type            cmd,
   output fgsr_pkg::fgsr_stat_type           stat
);
   import fgsr_pkg::*;

   localparam int SW  = $clog2(SNAP_DEPTH);
   localparam int SCW = $clog2(SNAP_DEPTH + 1);
   localparam int IW  = $clog2(INC_DEPTH);
   localparam int ICW = $clog2(INC_DEPTH + 1);

   // latched update
   logic        in_snap_ff, in_snap_in;
   logic [31:0] in_seq_ff, in_seq_in;
   logic [2:0]  in_type_ff, in_type_in;
   logic [31:0] in_order_ff, in_order_in;
   logic [63:0] in_body_ff, in_body_in;

   logic        rec_ff, rec_in;
   logic [31:0] exp_ff, exp_in;
   logic [2:0]  start_code_ff, start_code_in;
   logic [2:0]  end_code_ff, end_code_in;

   logic [SNAP_DEPTH-1:0] snap_valid_ff, snap_valid_in;
   logic [SCW-1:0]        snap_cnt_ff, snap_cnt_in;
   logic [INC_DEPTH-1:0]  inc_valid_ff, inc_valid_in;

   fgsr_snap_entry_type snap_mem [SNAP_DEPTH];
   fgsr_inc_entry_type  inc_mem [INC_DEPTH];
   fgsr_snap_entry_type snap_rd_ff;
   fgsr_inc_entry_type  inc_rd_ff;
   logic [IW-1:0]       inc_raddr_ff, inc_raddr_in;
   logic [SW-1:0]       snap_raddr;
   logic                snap_rd_en, inc_rd_en;

   logic [SW-1:0]  sidx_ff, sidx_in;
   logic [IW-1:0]  iidx_ff, iidx_in;
   logic [ICW-1:0] icnt_ff, icnt_in;
   logic [ICW-1:0] jcnt_ff, jcnt_in;
   logic [31:0]    max_ff, max_in;
   logic [32:0]    next_ff, next_in;

   logic         pend_valid_ff, pend_valid_in;
   fgsr_res_type pend_ff, pend_in;
   logic         rsp_valid_ff, rsp_valid_in;
   fgsr_res_type rsp_ff, rsp_in;
   logic         rsp_last_ff, rsp_last_in;

   logic          mod_start, mod_done;
   logic [32:0]   mod_value;
   logic [IW-1:0] residue;

   logic          rsp_free, push_ok, push_en;
   fgsr_res_type  push_data;
   logic [SW-1:0] seq_idx;
   logic          seq_in_range;
   logic [33:0]   chk_lhs, chk_rhs;

   fgsr_mod #(.MODULUS(INC_DEPTH)) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .value   (mod_value),
      .done    (mod_done),
      .residue (residue)
   );

   function automatic logic is_marker(input logic [2:0] t, input logic [2:0] s,
                                      input logic [2:0] e);
      return (t == s) || (t == e);
   endfunction

   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign push_ok      = !pend_valid_ff || rsp_free;
   assign seq_idx      = in_seq_ff[SW-1:0];
   assign seq_in_range = (in_seq_ff < 32'(SNAP_DEPTH));
   assign mod_start    = (cmd.op == OP_MOD_SEQ) || (cmd.op == OP_MOD_NEXT);
   assign mod_value    = (cmd.op == OP_MOD_SEQ) ? {1'b0, in_seq_ff} : next_ff;
   assign chk_lhs      = 34'(max_ff) + 34'd1;
   assign chk_rhs      = 34'(next_ff) + 34'(icnt_ff);

   always_comb begin
      push_en   = 1'b0;
      push_data = '0;
      unique case (cmd.op)
         OP_FWD: begin
            push_en   = 1'b1;
            push_data = '{KIND_FWD, in_type_ff, in_order_ff, in_body_ff};
         end
         OP_JOIN: begin
            push_en        = 1'b1;
            push_data.kind = KIND_JOIN;
         end
         OP_EMIT_SNAP: begin
            push_en   = !is_marker(snap_rd_ff.utype, start_code_ff, end_code_ff);
            push_data = '{KIND_FWD, snap_rd_ff.utype, snap_rd_ff.order, snap_rd_ff.body};
         end
         OP_EMIT_INC: begin
            push_en   = !is_marker(inc_rd_ff.utype, start_code_ff, end_code_ff);
            push_data = '{KIND_FWD, inc_rd_ff.utype, inc_rd_ff.order, inc_rd_ff.body};
         end
         OP_LEAVE: begin
            push_en        = 1'b1;
            push_data.kind = KIND_LEAVE;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      snap_rd_en = 1'b0;
      snap_raddr = '0;
      unique case (cmd.op)
         OP_RD_SNAP0: snap_rd_en = 1'b1;
         OP_RD_SNAPN: begin
            snap_rd_en = 1'b1;
            snap_raddr = SW'(snap_cnt_ff - SCW'(1));
         end
         OP_RD_SNAPI: begin
            snap_rd_en = 1'b1;
            snap_raddr = sidx_ff;
         end
         default: begin
         end
      endcase
      inc_rd_en = (cmd.op == OP_RD_INC) || (cmd.op == OP_RD_INCSLOT);
   end

   always_comb begin
      in_snap_in    = in_snap_ff;
      in_seq_in     = in_seq_ff;
      in_type_in    = in_type_ff;
      in_order_in   = in_order_ff;
      in_body_in    = in_body_ff;
      rec_in        = rec_ff;
      exp_in        = exp_ff;
      start_code_in = start_code_ff;
      end_code_in   = end_code_ff;
      snap_valid_in = snap_valid_ff;
      snap_cnt_in   = snap_cnt_ff;
      inc_valid_in  = inc_valid_ff;
      inc_raddr_in  = inc_raddr_ff;
      sidx_in       = sidx_ff;
      iidx_in       = iidx_ff;
      icnt_in       = icnt_ff;
      jcnt_in       = jcnt_ff;
      max_in        = max_ff;
      next_in       = next_ff;

      unique case (cmd.op)
         OP_LATCH: begin
            in_snap_in  = req_tuser;
            in_seq_in   = req_tdata[31:0];
            in_type_in  = req_tdata[34:32];
            in_order_in = req_tdata[66:35];
            in_body_in  = req_tdata[130:67];
         end
         OP_FWD: exp_in = exp_ff + 32'd1;
         OP_JOIN: begin
            rec_in        = 1'b1;
            snap_valid_in = '0;
            snap_cnt_in   = '0;
            inc_valid_in  = '0;
         end
         OP_SNAP_WR: begin
            if (!seq_in_range) begin
               snap_valid_in = '0;
               snap_cnt_in   = '0;
            end else if (snap_valid_ff[seq_idx]) begin
               // duplicate number restarts the snapshot
               snap_valid_in = SNAP_DEPTH'(1) << seq_idx;
               snap_cnt_in   = SCW'(1);
            end else begin
               snap_valid_in = snap_valid_ff | (SNAP_DEPTH'(1) << seq_idx);
               snap_cnt_in   = snap_cnt_ff + SCW'(1);
            end
         end
         OP_INC_WR: inc_valid_in = inc_valid_ff | (INC_DEPTH'(1) << residue);
         OP_SNAP_CLR: begin
            snap_valid_in = '0;
            snap_cnt_in   = '0;
         end
         OP_SET_NEXT: begin
            next_in = {1'b0, snap_rd_ff.order} + 33'd1;
            iidx_in = '0;
            icnt_in = '0;
            max_in  = '0;
         end
         OP_RD_INC: inc_raddr_in = iidx_ff;
         OP_SWEEP: begin
            if (inc_valid_ff[inc_raddr_ff] && ({1'b0, inc_rd_ff.tag} >= next_ff)) begin
               icnt_in = icnt_ff + ICW'(1);
               if (inc_rd_ff.tag > max_ff) begin
                  max_in = inc_rd_ff.tag;
               end
            end
            iidx_in = iidx_ff + IW'(1);
         end
         OP_MOD_NEXT: sidx_in = '0;
         OP_INIT_INC: begin
            iidx_in = residue;
            jcnt_in = '0;
         end
         OP_EMIT_SNAP: sidx_in = sidx_ff + SW'(1);
         OP_RD_INCSLOT: inc_raddr_in = iidx_ff;
         OP_EMIT_INC: begin
            iidx_in = (iidx_ff == IW'(INC_DEPTH - 1)) ? '0 : iidx_ff + IW'(1);
            jcnt_in = jcnt_ff + ICW'(1);
         end
         OP_LEAVE: begin
            rec_in        = 1'b0;
            snap_valid_in = '0;
            snap_cnt_in   = '0;
            inc_valid_in  = '0;
            exp_in        = 32'(next_ff + 33'(icnt_ff));
         end
         default: begin
         end
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INIT_SEQ:   exp_in        = csr_wr_data;
            CSR_START_CODE: start_code_in = csr_wr_data[2:0];
            CSR_END_CODE:   end_code_in   = csr_wr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   // result stage: pend holds the newest result until it is known whether it is the last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (push_en) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = push_data;
         pend_valid_in = 1'b1;
      end else if (cmd.op == OP_FLUSH && pend_valid_ff) begin
         rsp_in        = pend_ff;
         rsp_last_in   = 1'b1;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff        <= 1'b0;
         exp_ff        <= 32'd1;
         start_code_ff <= 3'd1;
         end_code_ff   <= 3'd2;
         snap_valid_ff <= '0;
         snap_cnt_ff   <= '0;
         inc_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rec_ff        <= rec_in;
         exp_ff        <= exp_in;
         start_code_ff <= start_code_in;
         end_code_ff   <= end_code_in;
         snap_valid_ff <= snap_valid_in;
         snap_cnt_ff   <= snap_cnt_in;
         inc_valid_ff  <= inc_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_snap_ff   <= in_snap_in;
      in_seq_ff    <= in_seq_in;
      in_type_ff   <= in_type_in;
      in_order_ff  <= in_order_in;
      in_body_ff   <= in_body_in;
      inc_raddr_ff <= inc_raddr_in;
      sidx_ff      <= sidx_in;
      iidx_ff      <= iidx_in;
      icnt_ff      <= icnt_in;
      jcnt_ff      <= jcnt_in;
      max_ff       <= max_in;
      next_ff      <= next_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SNAP_WR && seq_in_range) begin
         snap_mem[seq_idx] <= '{in_type_ff, in_order_ff, in_body_ff};
      end
      if (snap_rd_en) begin
         snap_rd_ff <= snap_mem[snap_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_INC_WR) begin
         inc_mem[residue] <= '{in_seq_ff, in_type_ff, in_order_ff, in_body_ff};
      end
      if (inc_rd_en) begin
         inc_rd_ff <= inc_mem[iidx_ff];
      end
   end

   always_comb begin
      stat.from_snapshot = in_snap_ff;
      stat.recovering    = rec_ff;
      stat.seq_hit       = (in_seq_ff == exp_ff);
      stat.push_ok       = push_ok;
      stat.rsp_free      = rsp_free;
      stat.pend_valid    = pend_valid_ff;
      stat.snap_empty    = (snap_cnt_ff == '0);
      stat.snap_contig   = snap_valid_ff[0] &&
                           ((snap_valid_ff & (snap_valid_ff + SNAP_DEPTH'(1))) == '0);
      stat.is_start      = (snap_rd_ff.utype == start_code_ff);
      stat.is_end        = (snap_rd_ff.utype == end_code_ff);
      stat.sweep_last    = (iidx_ff == IW'(INC_DEPTH - 1));
      stat.inc_ok        = (icnt_ff == '0) || (chk_lhs == chk_rhs);
      stat.mod_done      = mod_done;
      stat.snap_last     = (SCW'(sidx_ff) + SCW'(1) == snap_cnt_ff);
      stat.inc_done      = (jcnt_ff == icnt_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_ff.body, rsp_ff.order, rsp_ff.utype};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;
endmodule

// ----- design/fgsr_ctrl.sv -----
// fgsr_ctrl: sequencer for one update, issues one datapath command per cycle
`timescale 1ns / 1ps
module fgsr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  fgsr_pkg::fgsr_stat_type  stat,
   output fgsr_pkg::fgsr_cmd_type   cmd
);
   import fgsr_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECIDE,
      S_STORE,
      S_MODW_SEQ,
      S_CHK0,
      S_CHK1,
      S_CHK2,
      S_SWRD,
      S_SWEV,
      S_CHKINC,
      S_MODW_NEXT,
      S_SRD,
      S_SEM,
      S_ICHK,
      S_IEM,
      S_LEAVE,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (stat.from_snapshot && !stat.recovering) begin
               state_in = S_IDLE;
            end else if (!stat.recovering && stat.seq_hit) begin
               cmd.op   = OP_FWD;
               state_in = S_FLUSH;
            end else if (!stat.recovering) begin
               cmd.op   = OP_JOIN;
               state_in = S_STORE;
            end else begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            if (stat.from_snapshot) begin
               cmd.op   = OP_SNAP_WR;
               state_in = S_CHK0;
            end else begin
               cmd.op   = OP_MOD_SEQ;
               state_in = S_MODW_SEQ;
            end
         end
         S_MODW_SEQ: begin
            if (stat.mod_done) begin
               cmd.op   = OP_INC_WR;
               state_in = S_CHK0;
            end
         end
         S_CHK0: begin
            priority if (stat.snap_empty) begin
               state_in = S_FLUSH;
            end else if (!stat.snap_contig) begin
               cmd.op   = OP_SNAP_CLR;
               state_in = S_FLUSH;
            end else begin
               cmd.op   = OP_RD_SNAP0;
               state_in = S_CHK1;
            end
         end
         S_CHK1: begin
            if (!stat.is_start) begin
               cmd.op   = OP_SNAP_CLR;
               state_in = S_FLUSH;
            end else begin
               cmd.op   = OP_RD_SNAPN;
               state_in = S_CHK2;
            end
         end
         S_CHK2: begin
            if (!stat.is_end) begin
               state_in = S_FLUSH;
            end else begin
               cmd.op   = OP_SET_NEXT;
               state_in = S_SWRD;
            end
         end
         S_SWRD: begin
            cmd.op   = OP_RD_INC;
            state_in = S_SWEV;
         end
         S_SWEV: begin
            cmd.op   = OP_SWEEP;
            state_in = stat.sweep_last ? S_CHKINC : S_SWRD;
         end
         S_CHKINC: begin
            if (!stat.inc_ok) begin
               cmd.op   = OP_SNAP_CLR;
               state_in = S_FLUSH;
            end else begin
               cmd.op   = OP_MOD_NEXT;
               state_in = S_MODW_NEXT;
            end
         end
         S_MODW_NEXT: begin
            if (stat.mod_done) begin
               cmd.op   = OP_INIT_INC;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            cmd.op   = OP_RD_SNAPI;
            state_in = S_SEM;
         end
         S_SEM: begin
            if (stat.push_ok) begin
               cmd.op   = OP_EMIT_SNAP;
               state_in = stat.snap_last ? S_ICHK : S_SRD;
            end
         end
         S_ICHK: begin
            if (stat.inc_done) begin
               state_in = S_LEAVE;
            end else begin
               cmd.op   = OP_RD_INCSLOT;
               state_in = S_IEM;
            end
         end
         S_IEM: begin
            if (stat.push_ok) begin
               cmd.op   = OP_EMIT_INC;
               state_in = S_ICHK;
            end
         end
         S_LEAVE: begin
            if (stat.push_ok) begin
               cmd.op   = OP_LEAVE;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            priority if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.rsp_free) begin
               cmd.op   = OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
endmodule
